@@ sv/pixel_histogram_with_peak_scaling_defines.svh @@
// Assertion macros shared by the histogram checker.
`ifndef PIXEL_HISTOGRAM_WITH_PEAK_SCALING_DEFINES_SVH
`define PIXEL_HISTOGRAM_WITH_PEAK_SCALING_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define PHPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Clocked assertion on a result that is being offered.
`define PHPS_OUT_ASSERT(lbl, prop, msg) \
    `PHPS_ASSERT(lbl, i_res_valid |-> (prop), msg)

`endif

@@ sv/phps_pkg.sv @@
// Shared types and constants of the pixel histogram block.
package phps_pkg;

    localparam int REQ_W       = 2;
    localparam int PIX_W       = 8;
    localparam int ROWS_W      = 10;
    localparam int OUT_COUNT_W = 21;
    localparam int HEIGHT_W    = 10;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [REQ_W-1:0]    REQ_ADD    = 2'd0;
    localparam logic [REQ_W-1:0]    REQ_READ   = 2'd1;
    localparam logic [REQ_W-1:0]    REQ_CLEAR  = 2'd2;
    localparam logic [ROWS_W-1:0]   ROWS_RESET = 10'd125;
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 10'd1023;

    typedef enum logic [1:0] {
        CMD_ADD,
        CMD_READ,
        CMD_CLEAR
    } t_cmd;

    typedef struct packed {
        t_cmd             cmd;
        logic [PIX_W-1:0] idx;
    } t_q_entry;

    typedef struct packed {
        logic     valid;
        t_q_entry entry;
    } t_q_head;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

@@ sv/phps_if.sv @@
// Request, result and configuration channel interfaces of the histogram block.
interface phps_req_if import phps_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] req_type;
    logic [PIX_W-1:0] pixel;
    logic [PIX_W-1:0] bin;

    modport source (output valid, output req_type, output pixel, output bin, input ready);
    modport sink (input valid, input req_type, input pixel, input bin, output ready);
endinterface

interface phps_res_if import phps_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [PIX_W-1:0]       bin_index;
    logic [OUT_COUNT_W-1:0] bin_count;
    logic [HEIGHT_W-1:0]    bar_height;
    logic                   no_peak;
    logic                   drawn;

    modport source (output valid, output bin_index, output bin_count, output bar_height,
                    output no_peak, output drawn, input ready);
    modport sink (input valid, input bin_index, input bin_count, input bar_height,
                  input no_peak, input drawn, output ready);
endinterface

interface phps_cfg_if import phps_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ROWS_W-1:0] bar_rows;

    modport source (output valid, output bar_rows, input ready);
    modport sink (input valid, input bar_rows, output ready);
endinterface

@@ sv/pixel_histogram_with_peak_scaling.sv @@
// Top level of the pixel histogram with peak-scaled bar heights.
//
// Requests arrive on i_req: an add request counts a pixel into its bin, a read request
// returns one result on o_res with the bin's count and its bar height, and a clear request
// empties every bin and the peak. Unused request codes and out-of-range pixels are dropped.
// i_cfg writes the full-scale bar height and is always ready; the user must write it only
// while idle, as the block does not enforce this. A four-entry command queue separates
// request intake from the bin store, so requests keep being taken while the store works
// or while a result waits on a stalled receiver. An add request reads its bin from the
// store, then increments it and writes it back. A clear request needs no sweep, since the
// store keeps one valid flag per bin. A read request goes from the queue through the store
// read, the multiply, the restoring divider with one quotient bit per cycle over the
// COUNT_BITS + 10 bit product, and the result load; with a zero peak the divider is skipped.
// Results stay on o_res until taken; a stalled receiver halts the store once a second
// read result is ready, and the queue fills and drops i_req.ready after that.
// Reset empties the queue and the store, clears the peak and sets the bar height to 125.
module pixel_histogram_with_peak_scaling import phps_pkg::*; #(
    parameter int BINS       = 256,
    parameter int COUNT_BITS = 21
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    phps_req_if.sink   i_req,
    phps_cfg_if.sink   i_cfg,
    phps_res_if.source o_res
);

    logic [ROWS_W-1:0] r_bar_rows;
    t_q_head           head;
    logic              pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bar_rows <= ROWS_RESET;
        end else if (i_cfg.valid) begin
            r_bar_rows <= i_cfg.bar_rows;
        end
    end

    phps_front #(
        .BINS (BINS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_head  (head),
        .i_pop   (pop)
    );

    phps_back #(
        .BINS       (BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .o_pop      (pop),
        .i_bar_rows (r_bar_rows),
        .o_res      (o_res)
    );

endmodule

@@ sv/phps_front.sv @@
// Front end: accepts requests, classifies them and queues commands for the back end.
module phps_front import phps_pkg::*; #(
    parameter int BINS = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    phps_req_if.sink   i_req,
    output t_q_head    o_head,
    input  logic       i_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;
    localparam logic [PIX_W:0] BINS_LIM = (PIX_W + 1)'(BINS);

    t_q_entry         r_queue [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    t_q_entry new_entry;
    logic     keep;
    logic     push;
    logic     pop;

    always_comb begin
        new_entry.cmd = CMD_ADD;
        new_entry.idx = i_req.pixel;
        keep          = 1'b0;
        unique case (i_req.req_type)
            REQ_ADD: begin
                keep = {1'b0, i_req.pixel} < BINS_LIM;
            end
            REQ_READ: begin
                new_entry.cmd = CMD_READ;
                new_entry.idx = i_req.bin;
                keep          = 1'b1;
            end
            REQ_CLEAR: begin
                new_entry.cmd = CMD_CLEAR;
                new_entry.idx = '0;
                keep          = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign i_req.ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign push        = i_req.valid && i_req.ready && keep;
    assign pop         = i_pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= new_entry;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_queue[r_rd_ptr];

endmodule

@@ sv/phps_back.sv @@
// Back end: bin store, running peak, bar height divider and result register.
module phps_back import phps_pkg::*; #(
    parameter int BINS       = 256,
    parameter int COUNT_BITS = 21
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_q_head           i_head,
    output logic              o_pop,
    input  logic [ROWS_W-1:0] i_bar_rows,
    phps_res_if.source        o_res
);

    localparam int IDX_W  = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int PROD_W = COUNT_BITS + ROWS_W;
    localparam int STEP_W = $clog2(PROD_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(PROD_W - 1);
    localparam logic [PIX_W:0]    BINS_LIM  = (PIX_W + 1)'(BINS);
    localparam logic [PIX_W:0]    DRAW_LIM  = (PIX_W + 1)'(BINS - 1);

    t_state r_state, n_state;

    logic [COUNT_BITS-1:0] r_mem [BINS];
    logic [BINS-1:0]       r_valid;
    logic [COUNT_BITS-1:0] r_rd_data;
    logic                  r_rd_hit;
    logic [COUNT_BITS-1:0] r_peak;
    logic [PIX_W-1:0]      r_idx;
    logic                  r_inrange;
    logic                  r_drawable;
    logic [PROD_W-1:0]     r_prod;
    logic [COUNT_BITS-1:0] r_rem;
    logic [STEP_W-1:0]     r_step;
    logic [COUNT_BITS-1:0] r_count;
    logic                  r_nopk;
    logic                  r_drawn;

    logic                   r_out_valid;
    logic [PIX_W-1:0]       r_out_idx;
    logic [OUT_COUNT_W-1:0] r_out_count;
    logic [HEIGHT_W-1:0]    r_out_height;
    logic                   r_out_nopk;
    logic                   r_out_drawn;

    logic pop, clear, wr_en, mul_load, div_step, out_load, out_free;

    logic [IDX_W-1:0]      rd_addr;
    logic [IDX_W-1:0]      wr_addr;
    logic [COUNT_BITS-1:0] cur;
    logic [COUNT_BITS-1:0] inc;
    logic [COUNT_BITS-1:0] rd_count;
    logic [COUNT_BITS:0]   rem_sh;
    logic                  rem_ge;
    logic [HEIGHT_W-1:0]   height;

    assign out_free = !r_out_valid || o_res.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    unique case (i_head.entry.cmd)
                        CMD_ADD:  n_state = ST_ADD;
                        CMD_READ: n_state = ST_MUL;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_ADD: begin
                n_state = ST_IDLE;
            end
            ST_MUL: begin
                n_state = (r_peak != '0) ? ST_DIV : ST_OUT;
            end
            ST_DIV: begin
                n_state = (r_step == STEP_LAST) ? ST_OUT : ST_DIV;
            end
            ST_OUT: begin
                n_state = out_free ? ST_IDLE : ST_OUT;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        pop      = 1'b0;
        clear    = 1'b0;
        wr_en    = 1'b0;
        mul_load = 1'b0;
        div_step = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                pop   = i_head.valid;
                clear = i_head.valid && (i_head.entry.cmd == CMD_CLEAR);
            end
            ST_ADD:  wr_en    = 1'b1;
            ST_MUL:  mul_load = 1'b1;
            ST_DIV:  div_step = 1'b1;
            ST_OUT:  out_load = out_free;
            default: pop      = 1'b0;
        endcase
    end

    assign o_pop    = pop;
    assign rd_addr  = i_head.entry.idx[IDX_W-1:0];
    assign wr_addr  = r_idx[IDX_W-1:0];
    assign cur      = r_rd_hit ? r_rd_data : '0;
    assign inc      = (cur == '1) ? cur : cur + 1'b1;
    assign rd_count = (r_inrange && r_rd_hit) ? r_rd_data : '0;
    assign rem_sh   = {r_rem, r_prod[PROD_W-1]};
    assign rem_ge   = rem_sh >= {1'b0, r_peak};
    assign height   = (|r_prod[PROD_W-1:HEIGHT_W]) ? HEIGHT_MAX : r_prod[HEIGHT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_hit  <= r_valid[rd_addr];
        end
        if (wr_en) begin
            r_mem[wr_addr] <= inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_peak      <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (clear) begin
                r_valid <= '0;
                r_peak  <= '0;
            end else if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
                if (r_drawable && (inc > r_peak)) begin
                    r_peak <= inc;
                end
            end
            if (mul_load) begin
                r_step <= '0;
            end else if (div_step) begin
                r_step <= r_step + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_idx      <= i_head.entry.idx;
            r_inrange  <= {1'b0, i_head.entry.idx} < BINS_LIM;
            r_drawable <= {1'b0, i_head.entry.idx} < DRAW_LIM;
        end
        if (mul_load) begin
            r_count <= rd_count;
            r_nopk  <= (r_peak == '0);
            r_drawn <= r_inrange && r_drawable;
            r_rem   <= '0;
            r_prod  <= (r_peak == '0) ? '0 : PROD_W'(rd_count) * PROD_W'(i_bar_rows);
        end else if (div_step) begin
            r_rem  <= rem_ge ? COUNT_BITS'(rem_sh - {1'b0, r_peak}) : COUNT_BITS'(rem_sh);
            r_prod <= {r_prod[PROD_W-2:0], rem_ge};
        end
        if (out_load) begin
            r_out_idx    <= r_idx;
            r_out_count  <= OUT_COUNT_W'(r_count);
            r_out_height <= height;
            r_out_nopk   <= r_nopk;
            r_out_drawn  <= r_drawn;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.bin_index  = r_out_idx;
    assign o_res.bin_count  = r_out_count;
    assign o_res.bar_height = r_out_height;
    assign o_res.no_peak    = r_out_nopk;
    assign o_res.drawn      = r_out_drawn;

endmodule

@@ sv/phps_checker.sv @@
// Port-level checker for the histogram block and its bind to the top level.
`include "pixel_histogram_with_peak_scaling_defines.svh"

module phps_checker import phps_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_req_ready,
    input logic                   i_res_valid,
    input logic                   i_res_ready,
    input logic [PIX_W-1:0]       i_res_bin_index,
    input logic [OUT_COUNT_W-1:0] i_res_bin_count,
    input logic [HEIGHT_W-1:0]    i_res_bar_height,
    input logic                   i_res_no_peak,
    input logic                   i_res_drawn
);

    `PHPS_ASSERT(a_res_hold, i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_bin_index) && $stable(i_res_bin_count) && $stable(i_res_bar_height), "Stalled result changed.")
    `PHPS_OUT_ASSERT(a_nopk_height, !i_res_no_peak || (i_res_bar_height == '0), "Bar height is nonzero without a peak.")
    `PHPS_OUT_ASSERT(a_undrawn_empty, i_res_drawn || (i_res_bin_count != '0) || (i_res_bar_height == '0), "Empty undrawn bin has a bar height.")
    `PHPS_ASSERT(a_reset_idle, !$past(i_rst_n) |-> !i_res_valid && i_req_ready, "Block is not idle after reset.")

endmodule

bind pixel_histogram_with_peak_scaling phps_checker u_phps_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_ready      (i_req.ready),
    .i_res_valid      (o_res.valid),
    .i_res_ready      (o_res.ready),
    .i_res_bin_index  (o_res.bin_index),
    .i_res_bin_count  (o_res.bin_count),
    .i_res_bar_height (o_res.bar_height),
    .i_res_no_peak    (o_res.no_peak),
    .i_res_drawn      (o_res.drawn)
);
